@@ hdl/osr_pkg.sv @@
// Shared types and constants for the operand stack with roll.
// Used by osr_cell, osr_mod_unit and operand_stack_with_roll; depends on nothing.
`timescale 1ns / 1ps

package osr_pkg;

    // default sizes handed to the top level
    localparam int STACK_DEPTH_DEF = 256;
    localparam int DATA_WIDTH_DEF  = 64;

    // fixed field widths of the item
    localparam int FIELD_DATA_W = 64;
    localparam int CMD_W        = 3;
    localparam int CNT_W        = 9;
    localparam int AMT_W        = 32;
    localparam int IDX_W        = 8;
    localparam int ST_W         = 2;
    localparam int REM_W        = CNT_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ROLL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT = 3'd4;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_RANGE = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MOD,
        S_ROLL,
        S_POP,
        S_READ,
        S_FIN
    } t_state;

    // what every cell of the chain does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [CNT_W-1:0] seg_len;
    } t_cell_ctrl;

endpackage

@@ hdl/operand_stack_with_roll.sv @@
// Top level of the operand stack with roll: command sequencer and cell chain.
// Depends on osr_pkg, osr_cell and osr_mod_unit.
//
//   channel   valid        stall         payload
//   input     i_in_valid   o_in_stall    i_cmd i_push_value i_elem_count
//                                        i_roll_amount i_read_index
//   output    o_out_valid  i_out_stall   o_read_value o_depth_now o_status
//
// One item at a time. Push, count and every error are settled at decode; pop
// takes one pop step per entry; read rotates until the wanted entry is on top,
// then once more; roll waits for the serial modulo and its done flag, then one
// cell-chain rotation step per position moved. Reset empties the stack at once.
// A stalled result holds in the output register while the next item is
// taken; that item waits at its last step until the register frees.
`timescale 1ns / 1ps

module operand_stack_with_roll #(
    parameter int STACK_DEPTH = osr_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = osr_pkg::DATA_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic [osr_pkg::CMD_W-1:0]                i_cmd,
    input  logic [osr_pkg::FIELD_DATA_W-1:0]         i_push_value,
    input  logic [osr_pkg::CNT_W-1:0]                i_elem_count,
    input  logic signed [osr_pkg::AMT_W-1:0]         i_roll_amount,
    input  logic [osr_pkg::IDX_W-1:0]                i_read_index,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [osr_pkg::FIELD_DATA_W-1:0]         o_read_value,
    output logic [osr_pkg::CNT_W-1:0]                o_depth_now,
    output logic [osr_pkg::ST_W-1:0]                 o_status
);

    localparam int DepthW = $clog2(STACK_DEPTH + 1);

    osr_pkg::t_state                  r_state, n_state;
    logic [DepthW-1:0]                r_depth, n_depth;
    logic [osr_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic [osr_pkg::CNT_W-1:0]        r_seg, n_seg;
    logic [DATA_WIDTH-1:0]            r_rv, n_rv;
    osr_pkg::t_status                 r_st, n_st;

    logic [osr_pkg::CMD_W-1:0]        r_cmd;
    logic [DATA_WIDTH-1:0]            r_val;
    logic [osr_pkg::CNT_W-1:0]        r_n;
    logic signed [osr_pkg::AMT_W-1:0] r_amt;
    logic [osr_pkg::IDX_W-1:0]        r_idx;

    logic                             r_out_valid;
    logic [DATA_WIDTH-1:0]            r_out_rv;
    logic [osr_pkg::CNT_W-1:0]        r_out_depth;
    osr_pkg::t_status                 r_out_st;

    osr_pkg::t_cell_ctrl              w_ctrl;
    logic                             w_in_accept;
    logic                             w_out_load;
    logic                             w_mod_start;
    logic                             w_mod_done;
    logic [osr_pkg::REM_W-1:0]        w_mod_rem;
    logic                             w_n_over;
    logic [DATA_WIDTH-1:0]            w_cell [STACK_DEPTH];

    assign o_in_stall  = (r_state != osr_pkg::S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_n_over    = 32'(r_n) > 32'(r_depth);

    // cell chain: top of stack is cell 0
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev;
        logic [DATA_WIDTH-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = r_val;
        end else begin : g_mid
            assign w_prev = w_cell[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_next = w_cell[g];
        end else begin : g_inner
            assign w_next = w_cell[g+1];
        end
        osr_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_top   (w_cell[0]),
            .o_value (w_cell[g])
        );
    end

    // roll amount reduction
    osr_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mod_start),
        .i_amount  (r_amt),
        .i_divisor (r_n),
        .o_done    (w_mod_done),
        .o_rem     (w_mod_rem)
    );

    // sequence one command through the chain
    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_cnt       = r_cnt;
        n_seg       = r_seg;
        n_rv        = r_rv;
        n_st        = r_st;
        w_ctrl.op      = osr_pkg::CELL_HOLD;
        w_ctrl.seg_len = r_seg;
        w_mod_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            osr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = osr_pkg::S_EVAL;
            end
            osr_pkg::S_EVAL: begin
                n_rv    = '0;
                n_st    = osr_pkg::ST_OK;
                n_state = osr_pkg::S_FIN;
                priority if (r_cmd == osr_pkg::CMD_PUSH) begin
                    if (r_depth == DepthW'(STACK_DEPTH)) begin
                        n_st = osr_pkg::ST_OVER;
                    end else begin
                        w_ctrl.op = osr_pkg::CELL_PUSH;
                        n_depth   = r_depth + DepthW'(1);
                    end
                end else if (r_cmd == osr_pkg::CMD_POP || r_cmd == osr_pkg::CMD_ROLL) begin
                    priority if (r_n == '0) begin
                        n_st = osr_pkg::ST_RANGE;
                    end else if (w_n_over) begin
                        n_st = osr_pkg::ST_UNDER;
                    end else if (r_cmd == osr_pkg::CMD_POP) begin
                        n_depth = r_depth - DepthW'(r_n);
                        n_cnt   = r_n;
                        n_state = osr_pkg::S_POP;
                    end else begin
                        w_mod_start = 1'b1;
                        n_state     = osr_pkg::S_MOD;
                    end
                end else if (r_cmd == osr_pkg::CMD_READ) begin
                    if (32'(r_idx) >= 32'(r_depth)) begin
                        n_st = osr_pkg::ST_UNDER;
                    end else begin
                        n_cnt   = osr_pkg::CNT_W'(r_idx) + 1'b1;
                        n_seg   = osr_pkg::CNT_W'(r_idx) + 1'b1;
                        n_state = osr_pkg::S_READ;
                    end
                end else if (r_cmd == osr_pkg::CMD_COUNT) begin
                    n_st = osr_pkg::ST_OK;
                end else begin
                    n_st = osr_pkg::ST_RANGE;
                end
            end
            osr_pkg::S_POP: begin
                w_ctrl.op = osr_pkg::CELL_POP;
                n_cnt     = r_cnt - 1'b1;
                if (r_cnt == osr_pkg::CNT_W'(1)) n_state = osr_pkg::S_FIN;
            end
            osr_pkg::S_MOD: begin
                if (w_mod_done) begin
                    if (w_mod_rem == '0) begin
                        n_state = osr_pkg::S_FIN;
                    end else begin
                        n_cnt   = osr_pkg::CNT_W'(w_mod_rem);
                        n_seg   = r_n;
                        n_state = osr_pkg::S_ROLL;
                    end
                end
            end
            osr_pkg::S_ROLL: begin
                w_ctrl.op = osr_pkg::CELL_ROT;
                n_cnt     = r_cnt - 1'b1;
                if (r_cnt == osr_pkg::CNT_W'(1)) n_state = osr_pkg::S_FIN;
            end
            osr_pkg::S_READ: begin
                // after index steps the wanted entry sits in the top cell;
                // one more step puts the segment back in order
                w_ctrl.op = osr_pkg::CELL_ROT;
                n_cnt     = r_cnt - 1'b1;
                if (r_cnt == osr_pkg::CNT_W'(1)) begin
                    n_rv    = w_cell[0];
                    n_state = osr_pkg::S_FIN;
                end
            end
            osr_pkg::S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = osr_pkg::S_IDLE;
                end
            end
            default: n_state = osr_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= osr_pkg::S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: capture the item, hold working values and result
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cmd <= i_cmd;
            r_val <= i_push_value[DATA_WIDTH-1:0];
            r_n   <= i_elem_count;
            r_amt <= i_roll_amount;
            r_idx <= i_read_index;
        end
        r_cnt <= n_cnt;
        r_seg <= n_seg;
        r_rv  <= n_rv;
        r_st  <= n_st;
        if (w_out_load) begin
            r_out_rv    <= r_rv;
            r_out_depth <= osr_pkg::CNT_W'(r_depth);
            r_out_st    <= r_st;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = osr_pkg::FIELD_DATA_W'(r_out_rv);
    assign o_depth_now  = r_out_depth;
    assign o_status     = r_out_st;

    // a result appears only from the final step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == osr_pkg::S_FIN))
        else $error("result raised outside the final step");

    // depth stays within the store
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DepthW'(STACK_DEPTH))
        else $error("depth beyond stack size");

    // depth changes only when a command is decoded
    a_depth_only_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != osr_pkg::S_EVAL) |=> $stable(r_depth))
        else $error("depth changed outside decode");

    // reduced roll amount lies below the count
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == osr_pkg::S_MOD && w_mod_done)
            |-> (osr_pkg::CNT_W'(w_mod_rem) < r_n))
        else $error("roll remainder out of range");

endmodule

@@ hdl/osr_cell.sv @@
// One stack cell: holds a single entry and trades it with its neighbors.
// Depends on osr_pkg for the control struct.
`timescale 1ns / 1ps

module osr_cell #(
    parameter int DATA_WIDTH = osr_pkg::DATA_WIDTH_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                   i_clk,
    input  osr_pkg::t_cell_ctrl    i_ctrl,
    input  logic [DATA_WIDTH-1:0]  i_prev,
    input  logic [DATA_WIDTH-1:0]  i_next,
    input  logic [DATA_WIDTH-1:0]  i_top,
    output logic [DATA_WIDTH-1:0]  o_value
);

    localparam int Pos = CELL_IDX + 1;

    logic [DATA_WIDTH-1:0] r_value;

    // push moves entries away from the top, pop toward it; rotate cycles the
    // top seg_len entries up by one with the top wrapping to the segment end
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            osr_pkg::CELL_PUSH: r_value <= i_prev;
            osr_pkg::CELL_POP:  r_value <= i_next;
            osr_pkg::CELL_ROT: begin
                if (Pos < int'(i_ctrl.seg_len)) begin
                    r_value <= i_next;
                end else if (Pos == int'(i_ctrl.seg_len)) begin
                    r_value <= i_top;
                end
            end
            default: r_value <= r_value;
        endcase
    end

    assign o_value = r_value;

endmodule

@@ hdl/osr_mod_unit.sv @@
// Bit-serial reduction of a signed 32-bit amount modulo a 9-bit count.
// Result lies in 0 .. count-1; depends on osr_pkg for widths.
`timescale 1ns / 1ps

module osr_mod_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [osr_pkg::AMT_W-1:0]  i_amount,
    input  logic [osr_pkg::CNT_W-1:0]         i_divisor,
    output logic                              o_done,
    output logic [osr_pkg::REM_W-1:0]         o_rem
);

    localparam int StepW = $clog2(osr_pkg::AMT_W);

    logic                         r_busy;
    logic                         r_done;
    logic [StepW-1:0]             r_step;
    logic [osr_pkg::AMT_W-1:0]    r_mag;
    logic [osr_pkg::REM_W-1:0]    r_rem;
    logic                         r_neg;
    logic [osr_pkg::CNT_W-1:0]    r_div;

    logic [osr_pkg::AMT_W-1:0]    w_amt_u;
    logic [osr_pkg::AMT_W-1:0]    w_mag;
    logic [osr_pkg::REM_W:0]      w_trial;

    // magnitude of the amount; the most negative value maps to 2^31
    assign w_amt_u = $unsigned(i_amount);
    assign w_mag   = w_amt_u[osr_pkg::AMT_W-1] ? (~w_amt_u + 1'b1) : w_amt_u;

    // shift in the next dividend bit
    assign w_trial = {r_rem, r_mag[osr_pkg::AMT_W-1]};

    // control: run one step per cycle, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == StepW'(osr_pkg::AMT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: restoring remainder, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= w_mag;
            r_rem <= '0;
            r_neg <= w_amt_u[osr_pkg::AMT_W-1];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_mag <= {r_mag[osr_pkg::AMT_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= osr_pkg::REM_W'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= osr_pkg::REM_W'(w_trial);
            end
        end
    end

    // fold a negative remainder back into range
    assign o_rem  = (r_neg && (r_rem != '0))
                  ? osr_pkg::REM_W'(r_div - osr_pkg::CNT_W'(r_rem)) : r_rem;
    assign o_done = r_done;

endmodule
